[rtl/hme_pkg.sv]
// Shared types, codes and constants of the chained hash map engine.
package hme_pkg;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 64;
    localparam int TOTAL_W = 8;
    localparam int CFG_W   = 6;

    localparam logic [CFG_W-1:0] BUCKET_COUNT_RESET = 6'd31;

    // The remainder unit retires this many dividend bits per cycle.
    localparam int DIV_BITS_PER_STEP = 4;
    localparam int DIV_STEPS         = KEY_W / DIV_BITS_PER_STEP;
    localparam int DIV_CNT_W         = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        ACT_INSERT  = 2'd0,
        ACT_REPLACE = 2'd1,
        ACT_REMOVE  = 2'd2,
        ACT_LOOKUP  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_PRESENT   = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

    typedef struct packed {
        logic             start;
        logic [KEY_W-1:0] key;
        logic [CFG_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [CFG_W-1:0] rem;
    } t_div_rsp;

endpackage

[rtl/hme_if.sv]
// Handshake channel interfaces for requests, results and configuration.
interface hme_in_if;
    import hme_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    modport source (output valid, output action, output key, output value, input ready);
    modport sink   (input valid, input action, input key, input value, output ready);
endinterface

interface hme_out_if;
    import hme_pkg::*;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic [VALUE_W-1:0] found_value;
    logic [TOTAL_W-1:0] entry_total;
    modport source (output valid, output status, output found_value, output entry_total,
                    input ready);
    modport sink   (input valid, input status, input found_value, input entry_total,
                    output ready);
endinterface

interface hme_cfg_if;
    import hme_pkg::*;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/chained_hash_map_engine_top.sv]
// Top level of the chained hash map engine: sequencer, configuration and result register.
//
//   channel  | dir | beat carries                         | handshake
//   i_in     | in  | action, key, value                   | valid / ready
//   o_out    | out | status, found_value, entry_total     | valid / ready
//   i_cfg    | in  | bucket_count                         | valid / ready (always ready)
//
// A request runs from its beat through the remainder unit (S_DIV), the fill read (S_FILL),
// a read and compare (S_RD, S_CMP) for each way compared, one more read when no way
// matches, the action (S_ACT), a shift read and write (S_SHR, S_SHW) for each way that a
// remove closes up, and S_DONE. Ready returns in the same cycle as the result appears.
// After reset a clearing pass zeroes the fill memory bucket by bucket; no request
// is taken meanwhile. A finished result waits in the output register, and the next
// request is taken while it waits; only a second result stalls behind it.
module chained_hash_map_engine_top #(
    parameter int BUCKETS = 32,
    parameter int WAYS    = 4
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    hme_in_if.sink    i_in,
    hme_out_if.source o_out,
    hme_cfg_if.sink   i_cfg
);
    import hme_pkg::*;

    localparam int SLOTS = BUCKETS * WAYS;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int WW    = $clog2(WAYS + 1);

    typedef enum logic [9:0] {
        S_CLEAR = 10'b00_0000_0001,
        S_IDLE  = 10'b00_0000_0010,
        S_DIV   = 10'b00_0000_0100,
        S_FILL  = 10'b00_0000_1000,
        S_RD    = 10'b00_0001_0000,
        S_CMP   = 10'b00_0010_0000,
        S_ACT   = 10'b00_0100_0000,
        S_SHR   = 10'b00_1000_0000,
        S_SHW   = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } t_state;

    function automatic logic [AW-1:0] slot_addr(input logic [BW-1:0] b,
                                                input logic [WW-1:0] w);
        return AW'(int'(b) * WAYS + int'(w));
    endfunction

    t_state             r_state, n_state;
    logic [BW-1:0]      r_clr, n_clr;
    t_action            r_action, n_action;
    logic [KEY_W-1:0]   r_key, n_key;
    logic [VALUE_W-1:0] r_value, n_value;
    logic [CFG_W-1:0]   r_divisor, n_divisor;
    logic [BW-1:0]      r_bucket, n_bucket;
    logic [WW-1:0]      r_way, n_way;
    logic               r_hit, n_hit;
    t_status            r_status, n_status;
    logic [VALUE_W-1:0] r_found, n_found;
    logic [TOTAL_W-1:0] r_count, n_count;
    logic [CFG_W-1:0]   r_bucket_count, n_bucket_count;
    logic               r_out_valid, n_out_valid;
    t_status            r_out_status, n_out_status;
    logic [VALUE_W-1:0] r_out_found, n_out_found;
    logic [TOTAL_W-1:0] r_out_total, n_out_total;

    t_div_req           div_req;
    t_div_rsp           div_rsp;
    logic               in_fire;
    logic [CFG_W-1:0]   eff_divisor;

    logic               kv_we;
    logic [AW-1:0]      kv_waddr;
    logic [KEY_W-1:0]   wkey;
    logic [VALUE_W-1:0] wval;
    logic [AW-1:0]      kv_raddr;
    logic [KEY_W-1:0]   rkey;
    logic [VALUE_W-1:0] rval;
    logic               fill_we;
    logic [BW-1:0]      fill_waddr;
    logic [WW-1:0]      fill_wdata;
    logic [WW-1:0]      fill;

    hme_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    hme_store #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_store (
        .i_clk        (i_clk),
        .i_kv_we      (kv_we),
        .i_kv_waddr   (kv_waddr),
        .i_wkey       (wkey),
        .i_wval       (wval),
        .i_kv_raddr   (kv_raddr),
        .o_rkey       (rkey),
        .o_rval       (rval),
        .i_fill_we    (fill_we),
        .i_fill_waddr (fill_waddr),
        .i_fill_wdata (fill_wdata),
        .i_fill_raddr (r_bucket),
        .o_fill       (fill)
    );

    assign i_in.ready  = (r_state == S_IDLE);
    assign in_fire     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    // A count of zero means one bucket; counts above the table size saturate.
    always_comb begin
        eff_divisor = r_bucket_count;
        if (r_bucket_count == '0) begin
            eff_divisor = CFG_W'(1);
        end else if (int'(r_bucket_count) > BUCKETS) begin
            eff_divisor = CFG_W'(BUCKETS);
        end
    end

    assign div_req.start   = in_fire;
    assign div_req.key     = i_in.key;
    assign div_req.divisor = r_divisor;

    always_comb begin
        n_state        = r_state;
        n_clr          = r_clr;
        n_action       = r_action;
        n_key          = r_key;
        n_value        = r_value;
        n_divisor      = r_divisor;
        n_bucket       = r_bucket;
        n_way          = r_way;
        n_hit          = r_hit;
        n_status       = r_status;
        n_found        = r_found;
        n_count        = r_count;
        n_bucket_count = r_bucket_count;
        n_out_valid    = r_out_valid;
        n_out_status   = r_out_status;
        n_out_found    = r_out_found;
        n_out_total    = r_out_total;

        kv_we      = 1'b0;
        kv_waddr   = slot_addr(r_bucket, r_way);
        wkey       = r_key;
        wval       = r_value;
        kv_raddr   = slot_addr(r_bucket, r_way);
        fill_we    = 1'b0;
        fill_waddr = r_bucket;
        fill_wdata = fill;

        if (i_cfg.valid) begin
            n_bucket_count = i_cfg.data;
        end
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                fill_we    = 1'b1;
                fill_waddr = r_clr;
                fill_wdata = '0;
                n_clr      = r_clr + BW'(1);
                if (r_clr == BW'(BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_fire) begin
                    n_action  = t_action'(i_in.action);
                    n_key     = i_in.key;
                    n_value   = i_in.value;
                    n_divisor = eff_divisor;
                    n_status  = ST_OK;
                    n_found   = '0;
                    n_hit     = 1'b0;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    n_bucket = BW'(div_rsp.rem);
                    n_state  = S_FILL;
                end
            end
            S_FILL: begin
                n_way   = '0;
                n_state = S_RD;
            end
            S_RD: begin
                if (r_way < fill) begin
                    n_state = S_CMP;
                end else begin
                    n_state = S_ACT;
                end
            end
            S_CMP: begin
                if (rkey == r_key) begin
                    n_hit   = 1'b1;
                    n_state = S_ACT;
                end else begin
                    n_way   = r_way + WW'(1);
                    n_state = S_RD;
                end
            end
            S_ACT: begin
                n_state = S_DONE;
                case (r_action) inside
                    ACT_INSERT, ACT_REPLACE: begin
                        if (r_hit) begin
                            if (r_action == ACT_INSERT) begin
                                n_status = ST_PRESENT;
                            end else begin
                                kv_we = 1'b1;
                            end
                        end else if (int'(fill) >= WAYS) begin
                            n_status = ST_FULL;
                        end else begin
                            kv_we      = 1'b1;
                            kv_waddr   = slot_addr(r_bucket, fill);
                            fill_we    = 1'b1;
                            fill_wdata = fill + WW'(1);
                            n_count    = r_count + TOTAL_W'(1);
                        end
                    end
                    ACT_REMOVE: begin
                        if (!r_hit) begin
                            n_status = ST_NOT_FOUND;
                        end else if ((r_way + WW'(1)) < fill) begin
                            n_state = S_SHR;
                        end else begin
                            fill_we    = 1'b1;
                            fill_wdata = fill - WW'(1);
                            n_count    = r_count - TOTAL_W'(1);
                        end
                    end
                    default: begin
                        if (r_hit) begin
                            n_found = rval;
                        end else begin
                            n_status = ST_NOT_FOUND;
                        end
                    end
                endcase
            end
            S_SHR: begin
                kv_raddr = slot_addr(r_bucket, r_way + WW'(1));
                n_state  = S_SHW;
            end
            S_SHW: begin
                // Move the next way down into the gap, then step on.
                kv_we = 1'b1;
                wkey  = rkey;
                wval  = rval;
                n_way = r_way + WW'(1);
                if ((r_way + WW'(2)) < fill) begin
                    n_state = S_SHR;
                end else begin
                    fill_we    = 1'b1;
                    fill_wdata = fill - WW'(1);
                    n_count    = r_count - TOTAL_W'(1);
                    n_state    = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_found  = r_found;
                    n_out_total  = r_count;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr          <= '0;
            r_count        <= '0;
            r_bucket_count <= BUCKET_COUNT_RESET;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_clr          <= n_clr;
            r_count        <= n_count;
            r_bucket_count <= n_bucket_count;
            r_out_valid    <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action     <= n_action;
        r_key        <= n_key;
        r_value      <= n_value;
        r_divisor    <= n_divisor;
        r_bucket     <= n_bucket;
        r_way        <= n_way;
        r_hit        <= n_hit;
        r_status     <= n_status;
        r_found      <= n_found;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_total  <= n_out_total;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_out_status;
    assign o_out.found_value = r_out_found;
    assign o_out.entry_total = r_out_total;

endmodule

[rtl/hme_div.sv]
// Iterative remainder unit: key modulo bucket count, four bits per cycle.
module hme_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hme_pkg::t_div_req i_req,
    output hme_pkg::t_div_rsp o_rsp
);
    import hme_pkg::*;

    logic [KEY_W-1:0]     r_quo, n_quo;
    logic [CFG_W-1:0]     r_rem, n_rem;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_busy, n_busy;
    logic                 r_done, n_done;

    always_comb begin
        logic [CFG_W:0] v_part;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        v_part = '0;
        if (i_req.start) begin
            n_quo  = i_req.key;
            n_rem  = '0;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // The partial remainder stays below twice the divisor, so one
            // compare and subtract per bit restores it.
            for (int i = 0; i < DIV_BITS_PER_STEP; i++) begin
                v_part = {n_rem, n_quo[KEY_W-1]};
                if (v_part >= {1'b0, i_req.divisor}) begin
                    v_part = v_part - {1'b0, i_req.divisor};
                end
                n_rem = v_part[CFG_W-1:0];
                n_quo = {n_quo[KEY_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.rem  = r_rem;

endmodule

[rtl/hme_store.sv]
// Slot key and value memories and the per-bucket fill memory.
module hme_store #(
    parameter int BUCKETS = 32,
    parameter int WAYS    = 4,
    localparam int SLOTS  = BUCKETS * WAYS,
    localparam int AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1,
    localparam int BW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
    localparam int WW     = $clog2(WAYS + 1)
) (
    input  logic                        i_clk,
    input  logic                        i_kv_we,
    input  logic [AW-1:0]               i_kv_waddr,
    input  logic [hme_pkg::KEY_W-1:0]   i_wkey,
    input  logic [hme_pkg::VALUE_W-1:0] i_wval,
    input  logic [AW-1:0]               i_kv_raddr,
    output logic [hme_pkg::KEY_W-1:0]   o_rkey,
    output logic [hme_pkg::VALUE_W-1:0] o_rval,
    input  logic                        i_fill_we,
    input  logic [BW-1:0]               i_fill_waddr,
    input  logic [WW-1:0]               i_fill_wdata,
    input  logic [BW-1:0]               i_fill_raddr,
    output logic [WW-1:0]               o_fill
);
    import hme_pkg::*;

    logic [KEY_W-1:0]   r_key_mem  [SLOTS];
    logic [VALUE_W-1:0] r_val_mem  [SLOTS];
    logic [WW-1:0]      r_fill_mem [BUCKETS];
    logic [KEY_W-1:0]   r_rkey;
    logic [VALUE_W-1:0] r_rval;
    logic [WW-1:0]      r_fill;

    always_ff @(posedge i_clk) begin
        if (i_kv_we) begin
            r_key_mem[i_kv_waddr] <= i_wkey;
            r_val_mem[i_kv_waddr] <= i_wval;
        end
        r_rkey <= r_key_mem[i_kv_raddr];
        r_rval <= r_val_mem[i_kv_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_fill_we) begin
            r_fill_mem[i_fill_waddr] <= i_fill_wdata;
        end
        r_fill <= r_fill_mem[i_fill_raddr];
    end

    assign o_rkey = r_rkey;
    assign o_rval = r_rval;
    assign o_fill = r_fill;

endmodule

[rtl/hme_checker.sv]
// Port-level checks of the chained hash map engine and their binding to the top level.
module hme_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        i_in_ready,
    input logic                        i_out_valid,
    input logic                        i_out_ready,
    input logic [1:0]                  i_out_status,
    input logic [hme_pkg::VALUE_W-1:0] i_out_found,
    input logic [hme_pkg::TOTAL_W-1:0] i_out_total
);
    import hme_pkg::*;

    // The clearing pass holds requests off straight after reset.
    a_clear_after_reset: assert property (@(posedge i_clk) !i_rst_n |=> !i_in_ready)
        else $error("request taken during the clearing pass");

    // A taken request occupies the sequencer, so ready drops after the beat.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("ready held after a request beat");

    // Only a successful lookup returns a value.
    a_found_needs_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_out_found != '0)) |-> (i_out_status == ST_OK))
        else $error("value returned with a failing status");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_out_status) && $stable(i_out_found) &&
         $stable(i_out_total)))
        else $error("stalled result beat changed");

endmodule

bind chained_hash_map_engine_top hme_checker u_hme_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_status (o_out.status),
    .i_out_found  (o_out.found_value),
    .i_out_total  (o_out.entry_total)
);

[tb/sv/tb_top.sv]
// Self-checking testbench of the chained hash map engine with a scoreboard that models the table.
module tb_top;
    import hme_pkg::*;

    localparam int BUCKETS     = 32;
    localparam int WAYS        = 4;
    localparam int SLOTS       = BUCKETS * WAYS;
    localparam int POOL        = 16;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 88;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct {
        t_status            status;
        logic [VALUE_W-1:0] found;
        logic [TOTAL_W-1:0] total;
    } t_table_reply;

    class hash_table_scoreboard;
        logic [KEY_W-1:0]   stored_key   [SLOTS];
        logic [VALUE_W-1:0] stored_value [SLOTS];
        int unsigned        ways_used    [BUCKETS];
        logic [TOTAL_W-1:0] pair_total;
        logic [CFG_W-1:0]   bucket_count;
        t_table_reply       replies_due [$];
        int                 mismatches;
        int                 requests_noted;
        int                 replies_seen;
        int                 status_seen [4];

        function new();
            foreach (ways_used[b]) ways_used[b] = 0;
            foreach (status_seen[s]) status_seen[s] = 0;
            pair_total     = '0;
            bucket_count   = BUCKET_COUNT_RESET;
            mismatches     = 0;
            requests_noted = 0;
            replies_seen   = 0;
        endfunction

        function void set_bucket_count(logic [CFG_W-1:0] n);
            bucket_count = n;
        endfunction

        function int pending();
            return replies_due.size();
        endfunction

        function t_status add_pair(int unsigned b, logic [KEY_W-1:0] key,
                                   logic [VALUE_W-1:0] value);
            if (ways_used[b] >= WAYS) return ST_FULL;
            stored_key[b * WAYS + ways_used[b]]   = key;
            stored_value[b * WAYS + ways_used[b]] = value;
            ways_used[b]++;
            pair_total++;
            return ST_OK;
        endfunction

        function void note_request(t_action act, logic [KEY_W-1:0] key,
                                   logic [VALUE_W-1:0] value);
            int unsigned  n;
            int unsigned  b;
            int unsigned  base;
            int unsigned  hit_way;
            int unsigned  i;
            bit           hit;
            t_table_reply r;
            // A count of zero means one bucket; anything above the table size saturates.
            n = 32'(bucket_count);
            if (n == 0) n = 1;
            if (n > BUCKETS) n = BUCKETS;
            b       = key % n;
            base    = b * WAYS;
            hit     = 1'b0;
            hit_way = 0;
            for (i = 0; i < ways_used[b]; i++) begin
                if (!hit && stored_key[base + i] == key) begin
                    hit     = 1'b1;
                    hit_way = i;
                end
            end
            r.status = ST_OK;
            r.found  = '0;
            case (act)
                ACT_INSERT: begin
                    if (hit) r.status = ST_PRESENT;
                    else r.status = add_pair(b, key, value);
                end
                ACT_REPLACE: begin
                    if (hit) stored_value[base + hit_way] = value;
                    else r.status = add_pair(b, key, value);
                end
                ACT_REMOVE: begin
                    if (hit) begin
                        // Later ways move down one place so the bucket keeps its order.
                        for (i = hit_way; i + 1 < ways_used[b]; i++) begin
                            stored_key[base + i]   = stored_key[base + i + 1];
                            stored_value[base + i] = stored_value[base + i + 1];
                        end
                        ways_used[b]--;
                        pair_total--;
                    end else begin
                        r.status = ST_NOT_FOUND;
                    end
                end
                default: begin
                    if (hit) r.found = stored_value[base + hit_way];
                    else r.status = ST_NOT_FOUND;
                end
            endcase
            r.total = pair_total;
            status_seen[r.status]++;
            requests_noted++;
            replies_due.push_back(r);
        endfunction

        task report(string msg);
            mismatches++;
            $display("ERROR: %s", msg);
        endtask

        task check_result(logic [1:0] status, logic [VALUE_W-1:0] found,
                          logic [TOTAL_W-1:0] total);
            t_table_reply due;
            if (replies_due.size() == 0) begin
                report($sformatf("result beat with nothing outstanding: status %0d", status));
                return;
            end
            due = replies_due.pop_front();
            replies_seen++;
            if (status !== due.status)
                report($sformatf("reply %0d status: got %0d, expected %s",
                                 replies_seen, status, due.status.name()));
            if (found !== due.found)
                report($sformatf("reply %0d found_value: got %h, expected %h",
                                 replies_seen, found, due.found));
            if (total !== due.total)
                report($sformatf("reply %0d entry_total: got %0d, expected %0d",
                                 replies_seen, total, due.total));
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    hme_in_if  in_ch ();
    hme_out_if out_ch ();
    hme_cfg_if cfg_ch ();

    chained_hash_map_engine_top #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    hash_table_scoreboard sb = new();

    bit               idling_on = 1'b1;
    logic [KEY_W-1:0] key_pool [POOL];
    logic [CFG_W-1:0] phase_setting [PHASES] = '{6'd1, 6'd32, 6'd0, 6'd63,
                                                 6'd2, 6'd31, 6'd17, 6'd5};
    int unsigned      cycle_count = 0;

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d replies outstanding.",
                     cycle_count, sb.pending());
            $display("chained_hash_map_engine_top regression: fail");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            sb.check_result(out_ch.status, out_ch.found_value, out_ch.entry_total);
    end

    // Result side: ready drops in random bursts while idling is enabled.
    initial begin
        out_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (idling_on && $urandom_range(0, 3) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    end

    task automatic send_request(t_action act, logic [KEY_W-1:0] key,
                                logic [VALUE_W-1:0] value);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.action <= act;
        in_ch.key    <= key;
        in_ch.value  <= value;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        sb.note_request(act, key, value);
    endtask

    task automatic drain_replies();
        in_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_bucket_count(logic [CFG_W-1:0] n);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= n;
        do @(posedge i_clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        sb.set_bucket_count(n);
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        return {$urandom, $urandom};
    endfunction

    // Runs at the reset count of 31, so keys 0, 31, 62, 93, 124 and 155 share bucket zero.
    task automatic run_directed();
        send_request(ACT_INSERT,  32'd0,   '0);
        send_request(ACT_INSERT,  32'd31,  random_value());
        send_request(ACT_INSERT,  32'd62,  random_value());
        send_request(ACT_INSERT,  32'd93,  '1);
        send_request(ACT_INSERT,  32'd124, random_value());
        send_request(ACT_INSERT,  32'd31,  random_value());
        send_request(ACT_REPLACE, 32'd155, random_value());
        send_request(ACT_REPLACE, 32'd62,  random_value());
        send_request(ACT_LOOKUP,  32'd62,  random_value());
        send_request(ACT_REMOVE,  32'd31,  random_value());
        send_request(ACT_LOOKUP,  32'd93,  random_value());
        send_request(ACT_LOOKUP,  32'd0,   random_value());
        send_request(ACT_REMOVE,  32'd31,  random_value());
        send_request(ACT_LOOKUP,  32'd5,   random_value());
        send_request(ACT_REMOVE,  32'd7,   random_value());
        send_request(ACT_INSERT,  '1,      '1);
        send_request(ACT_LOOKUP,  '1,      '0);
        send_request(ACT_REPLACE, '1,      '0);
        send_request(ACT_LOOKUP,  '1,      '1);
        send_request(ACT_INSERT,  32'd124, random_value());
        send_request(ACT_LOOKUP,  32'd124, random_value());
        send_request(ACT_REMOVE,  32'd0,   random_value());
        send_request(ACT_LOOKUP,  32'd93,  random_value());
        send_request(ACT_REMOVE,  32'd124, random_value());
        send_request(ACT_LOOKUP,  32'd124, random_value());
    endtask

    // The first few pool keys survive every change of count, so pairs stranded in
    // their old buckets keep being looked for.
    task automatic run_phase(logic [CFG_W-1:0] setting, int items);
        int unsigned      n;
        logic [KEY_W-1:0] anchor;
        logic [KEY_W-1:0] key;
        t_action          act;
        drain_replies();
        write_bucket_count(setting);
        n = 32'(setting);
        if (n == 0) n = 1;
        if (n > BUCKETS) n = BUCKETS;
        anchor = $urandom;
        for (int k = 3; k < POOL; k++)
            key_pool[k] = (k < 8) ? $urandom : anchor + (k - 8) * n;
        repeat (items) begin
            act = t_action'($urandom_range(0, 3));
            key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL - 1)]
                                               : $urandom;
            send_request(act, key, random_value());
        end
    endtask

    initial begin
        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.action <= ACT_INSERT;
        in_ch.key    <= '0;
        in_ch.value  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        foreach (key_pool[k]) key_pool[k] = $urandom;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        for (int p = 0; p < PHASES; p++) begin
            idling_on = (p != PHASES - 1);
            run_phase(phase_setting[p], PHASE_ITEMS);
        end
        drain_replies();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Checked %0d of %0d replies over %0d bucket-count settings.",
                 sb.replies_seen, sb.requests_noted, PHASES + 1);
        $display("Replies seen: %0d ok, %0d key present, %0d not found, %0d bucket full.",
                 sb.status_seen[ST_OK], sb.status_seen[ST_PRESENT],
                 sb.status_seen[ST_NOT_FOUND], sb.status_seen[ST_FULL]);
        if (sb.mismatches == 0) begin
            $display("chained_hash_map_engine_top regression: pass");
        end else begin
            $display("chained_hash_map_engine_top regression: fail");
        end
        $finish;
    end

endmodule

[chained_hash_map_engine_top.f]
rtl/hme_pkg.sv
rtl/hme_if.sv
rtl/hme_div.sv
rtl/hme_store.sv
rtl/chained_hash_map_engine_top.sv
rtl/hme_checker.sv
tb/sv/tb_top.sv
